// ===== rtl/rbs_pkg.sv =====
// Shared types and constants for the ray/box slab intersection block.
// No dependencies; used by every module under rtl.
package rbs_pkg;

    localparam int unsigned IN_W    = 32;
    localparam int unsigned NUM_W   = 48;              // |bound - origin| << 16
    localparam int unsigned DEN_W   = 32;              // |dir|
    localparam int unsigned T_W     = NUM_W + 1;       // signed slab parameter
    localparam int unsigned DIST_W  = 31;
    localparam int unsigned DIV_LAT = NUM_W + 1;       // quotient stages plus sign fix
    localparam int unsigned LANE_LAT = DIV_LAT + 1;    // operand stage in front
    localparam int unsigned PIPE_LAT = LANE_LAT + 2;   // two merge stages
    localparam int unsigned NUM_AXES = 3;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic signed [1:0] NRM_POS  = 2'sb01;
    localparam logic signed [1:0] NRM_NEG  = 2'sb11;
    localparam logic signed [1:0] NRM_ZERO = 2'sb00;

    // per-axis information that travels beside the quotients
    typedef struct packed {
        logic              bounded;
        logic              outside;
        logic signed [1:0] dsg;
    } side_t;

    typedef struct packed {
        side_t                 side;
        logic signed [T_W-1:0] tlo;
        logic signed [T_W-1:0] thi;
    } lane_res_t;

endpackage

// ===== rtl/rbs_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, signed result.
// Depends on rbs_pkg for widths.
module rbs_div
(
    input  logic                               clk,
    input  logic                               en,
    input  logic                               neg,
    input  logic [rbs_pkg::NUM_W-1:0]          num_mag,
    input  logic [rbs_pkg::DEN_W-1:0]          den_mag,
    output logic signed [rbs_pkg::T_W-1:0]     quo
);

    localparam int unsigned NB = rbs_pkg::NUM_W;
    localparam int unsigned DW = rbs_pkg::DEN_W;

    logic [NB-1:0] acc_reg [0:NB-1];
    logic [DW-1:0] rem_reg [0:NB-1];
    logic [DW-1:0] den_reg [0:NB-1];
    logic          neg_reg [0:NB-1];
    logic signed [rbs_pkg::T_W-1:0] quo_reg;

    genvar k;
    generate
        for (k = 0; k < NB; k++)
        begin : g_stage
            logic [NB-1:0] acc_in;
            logic [DW-1:0] rem_in;
            logic [DW-1:0] den_in;
            logic          neg_in;
            logic [DW:0]   trial;
            logic [DW:0]   diff;
            logic          ge;
            logic [NB-1:0] acc_next;
            logic [DW-1:0] rem_next;

            if (k == 0)
            begin : g_first
                assign acc_in = num_mag;
                assign rem_in = '0;
                assign den_in = den_mag;
                assign neg_in = neg;
            end
            else
            begin : g_rest
                assign acc_in = acc_reg[k-1];
                assign rem_in = rem_reg[k-1];
                assign den_in = den_reg[k-1];
                assign neg_in = neg_reg[k-1];
            end

            always_comb
            begin
                trial    = {rem_in, acc_in[NB-1]};
                diff     = trial - {1'b0, den_in};
                ge       = (trial >= {1'b0, den_in});
                rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
                acc_next = {acc_in[NB-2:0], ge};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    acc_reg[k] <= acc_next;
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_in;
                    neg_reg[k] <= neg_in;
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= neg_reg[NB-1] ? -$signed({1'b0, acc_reg[NB-1]})
                                     : $signed({1'b0, acc_reg[NB-1]});
        end
    end

    assign quo = quo_reg;

endmodule

// ===== rtl/rbs_lane.sv =====
// One axis lane: slab entry/exit parameters through two pipelined dividers.
// Depends on rbs_pkg and rbs_div.
module rbs_lane
(
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [rbs_pkg::IN_W-1:0]   origin,
    input  logic signed [rbs_pkg::IN_W-1:0]   dir,
    input  logic signed [rbs_pkg::IN_W-1:0]   box_lo,
    input  logic signed [rbs_pkg::IN_W-1:0]   box_hi,
    output rbs_pkg::lane_res_t                res
);

    localparam int unsigned IW = rbs_pkg::IN_W;

    logic signed [IW:0]          dlo;
    logic signed [IW:0]          dhi;
    logic signed [IW:0]          dir_ext;
    logic [IW-1:0]               mlo;
    logic [IW-1:0]               mhi;
    logic [IW:0]                 mdir;
    rbs_pkg::side_t              side_next;

    logic [rbs_pkg::NUM_W-1:0]   lo_mag_reg;
    logic [rbs_pkg::NUM_W-1:0]   hi_mag_reg;
    logic [rbs_pkg::DEN_W-1:0]   den_reg;
    logic                        lo_neg_reg;
    logic                        hi_neg_reg;
    rbs_pkg::side_t              side_reg [0:rbs_pkg::DIV_LAT];

    logic signed [rbs_pkg::T_W-1:0] tlo;
    logic signed [rbs_pkg::T_W-1:0] thi;

    always_comb
    begin
        dlo     = {box_lo[IW-1], box_lo} - {origin[IW-1], origin};
        dhi     = {box_hi[IW-1], box_hi} - {origin[IW-1], origin};
        dir_ext = {dir[IW-1], dir};
        mlo     = dlo[IW] ? IW'(-dlo) : dlo[IW-1:0];
        mhi     = dhi[IW] ? IW'(-dhi) : dhi[IW-1:0];
        mdir    = dir[IW-1] ? -dir_ext : dir_ext;
        side_next.bounded = (dir != '0);
        side_next.outside = (dir == '0) && ((origin < box_lo) || (origin > box_hi));
        side_next.dsg     = (dir == '0) ? rbs_pkg::NRM_ZERO
                          : (dir[IW-1] ? rbs_pkg::NRM_NEG : rbs_pkg::NRM_POS);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_mag_reg  <= {mlo, 16'h0000};
            hi_mag_reg  <= {mhi, 16'h0000};
            den_reg     <= mdir[rbs_pkg::DEN_W-1:0];
            lo_neg_reg  <= dlo[IW] ^ dir[IW-1];
            hi_neg_reg  <= dhi[IW] ^ dir[IW-1];
            side_reg[0] <= side_next;
            for (int i = 1; i <= rbs_pkg::DIV_LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    rbs_div u_div_lo
    (
        .clk     (clk),
        .en      (en),
        .neg     (lo_neg_reg),
        .num_mag (lo_mag_reg),
        .den_mag (den_reg),
        .quo     (tlo)
    );

    rbs_div u_div_hi
    (
        .clk     (clk),
        .en      (en),
        .neg     (hi_neg_reg),
        .num_mag (hi_mag_reg),
        .den_mag (den_reg),
        .quo     (thi)
    );

    always_comb
    begin
        res.side = side_reg[rbs_pkg::DIV_LAT];
        res.tlo  = tlo;
        res.thi  = thi;
    end

endmodule

// ===== rtl/rbs_merge.sv =====
// Merge stage: near/far reduction over the lanes, hit decision, normal pick.
// Depends on rbs_pkg. Two register stages, the second is the output register.
module rbs_merge
(
    input  logic                              clk,
    input  logic                              en,
    input  rbs_pkg::lane_res_t                lane [0:rbs_pkg::NUM_AXES-1],
    output logic                              hit,
    output logic [rbs_pkg::DIST_W-1:0]        distance,
    output logic signed [1:0]                 normal_x,
    output logic signed [1:0]                 normal_y,
    output logic signed [1:0]                 normal_z
);

    localparam int unsigned TW = rbs_pkg::T_W;
    localparam int unsigned NA = rbs_pkg::NUM_AXES;

    logic signed [TW-1:0] near_c;
    logic signed [TW-1:0] far_c;
    logic                 any_c;
    logic                 miss_c;

    logic signed [TW-1:0] near_reg;
    logic signed [TW-1:0] far_reg;
    logic                 any_reg;
    logic                 miss_reg;
    rbs_pkg::lane_res_t   lane_reg [0:NA-1];

    logic signed [TW-1:0] t_c;
    logic                 hit_c;
    logic [rbs_pkg::DIST_W-1:0] dist_c;
    logic signed [1:0]    nrm_c [0:NA-1];
    logic                 found;

    logic                 hit_reg;
    logic [rbs_pkg::DIST_W-1:0] dist_reg;
    logic signed [1:0]    nrm_reg [0:NA-1];

    always_comb
    begin
        logic signed [TW-1:0] s;
        logic signed [TW-1:0] b;
        near_c = '0;
        far_c  = '0;
        any_c  = 1'b0;
        miss_c = 1'b0;
        for (int a = 0; a < NA; a++)
        begin
            s = (lane[a].tlo < lane[a].thi) ? lane[a].tlo : lane[a].thi;
            b = (lane[a].tlo < lane[a].thi) ? lane[a].thi : lane[a].tlo;
            if (lane[a].side.outside)
            begin
                miss_c = 1'b1;
            end
            if (lane[a].side.bounded)
            begin
                if (!any_c || s > near_c)
                begin
                    near_c = s;
                end
                if (!any_c || b < far_c)
                begin
                    far_c = b;
                end
                any_c = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            near_reg <= near_c;
            far_reg  <= far_c;
            any_reg  <= any_c;
            miss_reg <= miss_c;
            for (int a = 0; a < NA; a++)
            begin
                lane_reg[a] <= lane[a];
            end
        end
    end

    always_comb
    begin
        t_c   = near_reg[TW-1] ? far_reg : near_reg;
        found = 1'b0;
        for (int a = 0; a < NA; a++)
        begin
            nrm_c[a] = rbs_pkg::NRM_ZERO;
        end
        // first bounded axis whose plane matches, min plane wins on a tie
        for (int a = 0; a < NA; a++)
        begin
            if (!found && lane_reg[a].side.bounded)
            begin
                if (t_c == lane_reg[a].tlo)
                begin
                    nrm_c[a] = -lane_reg[a].side.dsg;
                    found    = 1'b1;
                end
                else if (t_c == lane_reg[a].thi)
                begin
                    nrm_c[a] = lane_reg[a].side.dsg;
                    found    = 1'b1;
                end
            end
        end
        if (t_c > $signed({{(TW-rbs_pkg::DIST_W){1'b0}}, rbs_pkg::DIST_MAX}))
        begin
            dist_c = rbs_pkg::DIST_MAX;
        end
        else
        begin
            dist_c = t_c[rbs_pkg::DIST_W-1:0];
        end
        hit_c = 1'b1;
        if (miss_reg || (any_reg && (near_reg > far_reg || far_reg[TW-1])))
        begin
            hit_c  = 1'b0;
            dist_c = '0;
            for (int a = 0; a < NA; a++)
            begin
                nrm_c[a] = rbs_pkg::NRM_ZERO;
            end
        end
        else if (!any_reg)
        begin
            dist_c = rbs_pkg::DIST_MAX;
            for (int a = 0; a < NA; a++)
            begin
                nrm_c[a] = rbs_pkg::NRM_ZERO;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg  <= hit_c;
            dist_reg <= dist_c;
            for (int a = 0; a < NA; a++)
            begin
                nrm_reg[a] <= nrm_c[a];
            end
        end
    end

    assign hit      = hit_reg;
    assign distance = dist_reg;
    assign normal_x = nrm_reg[0];
    assign normal_y = nrm_reg[1];
    assign normal_z = nrm_reg[2];

endmodule

// ===== rtl/ray_box_slab_intersect_top.sv =====
// Ray versus axis-aligned box test by the slab method, Q16.16 fixed point.
// A new request is taken every cycle while the result side keeps up; each
// request gives one result through one operand stage, 48 divider stages of
// one quotient bit each, a sign stage, and two merge stages. The
// three axis lanes run in parallel, each with two pipelined dividers. When
// the result waits the whole pipeline holds. No reset-time sweep.
// Depends on rbs_pkg, rbs_lane, rbs_div and rbs_merge.
module ray_box_slab_intersect_top
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic signed [rbs_pkg::IN_W-1:0]          origin_x,
    input  logic signed [rbs_pkg::IN_W-1:0]          origin_y,
    input  logic signed [rbs_pkg::IN_W-1:0]          origin_z,
    input  logic signed [rbs_pkg::IN_W-1:0]          dir_x,
    input  logic signed [rbs_pkg::IN_W-1:0]          dir_y,
    input  logic signed [rbs_pkg::IN_W-1:0]          dir_z,
    input  logic signed [rbs_pkg::IN_W-1:0]          box_min_x,
    input  logic signed [rbs_pkg::IN_W-1:0]          box_min_y,
    input  logic signed [rbs_pkg::IN_W-1:0]          box_min_z,
    input  logic signed [rbs_pkg::IN_W-1:0]          box_max_x,
    input  logic signed [rbs_pkg::IN_W-1:0]          box_max_y,
    input  logic signed [rbs_pkg::IN_W-1:0]          box_max_z,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic                                     hit,
    output logic [rbs_pkg::DIST_W-1:0]               distance,
    output logic signed [1:0]                        normal_x,
    output logic signed [1:0]                        normal_y,
    output logic signed [1:0]                        normal_z
);

    localparam int unsigned NA = rbs_pkg::NUM_AXES;
    localparam int unsigned PL = rbs_pkg::PIPE_LAT;

    logic                            en;
    logic [PL-1:0]                   vld_reg;
    logic [PL-1:0]                   vld_next;
    rbs_pkg::lane_res_t              lane_res [0:NA-1];
    logic signed [rbs_pkg::IN_W-1:0] org [0:NA-1];
    logic signed [rbs_pkg::IN_W-1:0] dr  [0:NA-1];
    logic signed [rbs_pkg::IN_W-1:0] blo [0:NA-1];
    logic signed [rbs_pkg::IN_W-1:0] bhi [0:NA-1];

    assign org[0] = origin_x;   assign org[1] = origin_y;   assign org[2] = origin_z;
    assign dr[0]  = dir_x;      assign dr[1]  = dir_y;      assign dr[2]  = dir_z;
    assign blo[0] = box_min_x;  assign blo[1] = box_min_y;  assign blo[2] = box_min_z;
    assign bhi[0] = box_max_x;  assign bhi[1] = box_max_y;  assign bhi[2] = box_max_z;

    // whole pipeline advances unless a finished result is stalled
    assign en        = !vld_reg[PL-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[PL-1];
    assign vld_next  = {vld_reg[PL-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    genvar a;
    generate
        for (a = 0; a < NA; a++)
        begin : g_lane
            rbs_lane u_lane
            (
                .clk    (clk),
                .en     (en),
                .origin (org[a]),
                .dir    (dr[a]),
                .box_lo (blo[a]),
                .box_hi (bhi[a]),
                .res    (lane_res[a])
            );
        end
    endgenerate

    rbs_merge u_merge
    (
        .clk      (clk),
        .en       (en),
        .lane     (lane_res),
        .hit      (hit),
        .distance (distance),
        .normal_x (normal_x),
        .normal_y (normal_y),
        .normal_z (normal_z)
    );

`ifndef ASSERT_OFF
    a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> distance == '0 && normal_x == rbs_pkg::NRM_ZERO
                              && normal_y == rbs_pkg::NRM_ZERO
                              && normal_z == rbs_pkg::NRM_ZERO)
        else $error("miss result carries a distance or normal");

    a_one_normal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $countones({normal_x != rbs_pkg::NRM_ZERO,
                                  normal_y != rbs_pkg::NRM_ZERO,
                                  normal_z != rbs_pkg::NRM_ZERO}) <= 1)
        else $error("more than one normal component set");

    a_normal_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> normal_x != 2'sb10 && normal_y != 2'sb10 && normal_z != 2'sb10)
        else $error("normal component out of range");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(vld_reg))
        else $error("pipeline moved while result stalled");
`endif

endmodule
